### rtl/pbfl_pkg.sv
// Package for the packet buffer free list: payload types, codes and control structs.
`timescale 1ns / 1ps

package pbfl_pkg;

    // Default sizes of the pool and of one allocate batch.
    localparam int DEPTH_DEFAULT     = 4096;
    localparam int MAX_BATCH_DEFAULT = 64;

    // Field widths fixed by the item formats.
    localparam int CMD_W    = 2;
    localparam int COUNT_W  = 7;
    localparam int FIDX_W   = 12;
    localparam int STATUS_W = 2;
    localparam int ADDR_W   = 48;
    localparam int SIZE_W   = 22;
    localparam int ENTRY_W  = 13;
    localparam int CFG_IDX_W = 2;

    // Reset values of the configuration registers.
    localparam logic [ADDR_W-1:0]  BASE_RESET    = '0;
    localparam logic [SIZE_W-1:0]  SIZE_RESET    = SIZE_W'(2048);
    localparam logic [ENTRY_W-1:0] ENTRIES_RESET = ENTRY_W'(4096);

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REINIT = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SIZE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [COUNT_W-1:0] alloc_count;
        logic [FIDX_W-1:0]  free_index;
    } pbfl_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIDX_W-1:0]   buffer_index;
        logic [ADDR_W-1:0]   buffer_address;
        logic                last;
    } pbfl_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                latch_in;
        logic                sweep_start;
        logic                sweep_step;
        logic                init_finish;
        logic                pop_read;
        logic                pop_take;
        logic                free_clear;
        logic                free_link;
        logic                out_load;
        logic                out_from_pop;
        logic [STATUS_W-1:0] out_status;
    } pbfl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] in_cmd;
        logic             in_count_zero;
        logic             head_ok;
        logic             remain_one;
        logic             out_free;
        logic             sweep_done;
        logic             free_bad;
    } pbfl_stat_t;

endpackage

### rtl/pbfl_ctrl.sv
// Controller state machine of the packet buffer free list.
`timescale 1ns / 1ps

module pbfl_ctrl import pbfl_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  pbfl_stat_t stat,
    output pbfl_cmd_t  cmd
);

    localparam logic [2:0] S_BOOT    = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_A_READ  = 3'd2;
    localparam logic [2:0] S_A_POP   = 3'd3;
    localparam logic [2:0] S_F_CLEAR = 3'd4;
    localparam logic [2:0] S_F_LINK  = 3'd5;
    localparam logic [2:0] S_INIT    = 3'd6;
    localparam logic [2:0] S_EMIT    = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [STATUS_W-1:0] emit_status_reg, emit_status_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next       = state_reg;
        emit_status_next = emit_status_reg;
        cmd              = '0;
        cmd.out_status   = STATUS_OK;
        unique case (state_reg)
            S_BOOT: begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_done) begin
                    cmd.init_finish = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.latch_in = 1'b1;
                    case (stat.in_cmd)
                        CMD_ALLOC: begin
                            if (!stat.in_count_zero) begin
                                state_next = S_A_READ;
                            end
                        end
                        CMD_FREE: begin
                            state_next = S_F_CLEAR;
                        end
                        CMD_REINIT: begin
                            cmd.sweep_start = 1'b1;
                            state_next      = S_INIT;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_A_READ: begin
                if (!stat.head_ok) begin
                    if (stat.out_free) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = STATUS_EMPTY;
                        state_next     = S_IDLE;
                    end
                end else begin
                    cmd.pop_read = 1'b1;
                    state_next   = S_A_POP;
                end
            end
            S_A_POP: begin
                if (stat.out_free) begin
                    cmd.pop_take     = 1'b1;
                    cmd.out_load     = 1'b1;
                    cmd.out_from_pop = 1'b1;
                    state_next       = stat.remain_one ? S_IDLE : S_A_READ;
                end
            end
            S_F_CLEAR: begin
                if (stat.free_bad) begin
                    emit_status_next = STATUS_BAD_INDEX;
                    state_next       = S_EMIT;
                end else begin
                    cmd.free_clear = 1'b1;
                    state_next     = S_F_LINK;
                end
            end
            S_F_LINK: begin
                cmd.free_link    = 1'b1;
                emit_status_next = STATUS_OK;
                state_next       = S_EMIT;
            end
            S_INIT: begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_done) begin
                    cmd.init_finish  = 1'b1;
                    emit_status_next = STATUS_OK;
                    state_next       = S_EMIT;
                end
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = emit_status_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_BOOT;
            emit_status_reg <= STATUS_OK;
        end else begin
            state_reg       <= state_next;
            emit_status_reg <= emit_status_next;
        end
    end

endmodule

### rtl/pbfl_datapath.sv
// Datapath of the packet buffer free list: registers, link memory, address unit, output stage.
`timescale 1ns / 1ps

module pbfl_datapath import pbfl_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int MAX_BATCH = MAX_BATCH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pbfl_in_t             s_data,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  pbfl_cmd_t            cmd,
    output pbfl_stat_t           stat,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pbfl_out_t            m_data
);

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int RB_W    = $clog2(MAX_BATCH + 1);
    localparam int PROD_W  = IDX_W + SIZE_W;
    localparam int N_RESET = (32'(ENTRIES_RESET) > DEPTH) ? DEPTH : 32'(ENTRIES_RESET);

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] nxt;
    } link_t;

    // Configuration registers.
    logic [ADDR_W-1:0]  base_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [ENTRY_W-1:0] entries_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg    <= BASE_RESET;
            size_reg    <= SIZE_RESET;
            entries_reg <= ENTRIES_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BASE_ADDRESS:   base_reg    <= cfg_data;
                CFG_BUFFER_SIZE:    size_reg    <= cfg_data[SIZE_W-1:0];
                CFG_ENTRIES_IN_USE: entries_reg <= cfg_data[ENTRY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Entry count clamped to 1 .. DEPTH.
    logic [CNT_W-1:0] n_cur;
    always_comb begin
        if (entries_reg == '0) begin
            n_cur = CNT_W'(1);
        end else if (32'(entries_reg) > DEPTH) begin
            n_cur = CNT_W'(DEPTH);
        end else begin
            n_cur = CNT_W'(entries_reg);
        end
    end

    // Accepted item and batch counter.
    pbfl_in_t         in_reg;
    logic [RB_W-1:0]  remain_reg;
    logic [IDX_W-1:0] fidx;

    assign fidx = IDX_W'(in_reg.free_index);

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            in_reg <= s_data;
            if (32'(s_data.alloc_count) > MAX_BATCH) begin
                remain_reg <= RB_W'(MAX_BATCH);
            end else begin
                remain_reg <= RB_W'(s_data.alloc_count);
            end
        end else if (cmd.pop_take) begin
            remain_reg <= remain_reg - RB_W'(1);
        end
    end

    // List pointers and rebuild sweep.
    logic [IDX_W-1:0] head_reg, tail_reg, sweep_reg;
    logic             head_ok_reg;
    logic [CNT_W-1:0] n_sweep_reg;
    logic             sweep_done;
    link_t            rd_reg;

    assign sweep_done = (sweep_reg == IDX_W'(DEPTH - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            head_ok_reg <= 1'b1;
            tail_reg    <= IDX_W'(N_RESET - 1);
            sweep_reg   <= '0;
            n_sweep_reg <= CNT_W'(N_RESET);
        end else begin
            if (cmd.sweep_start) begin
                n_sweep_reg <= n_cur;
            end
            if (cmd.sweep_step) begin
                sweep_reg <= sweep_done ? '0 : sweep_reg + IDX_W'(1);
            end
            if (cmd.init_finish) begin
                head_reg    <= '0;
                head_ok_reg <= 1'b1;
                tail_reg    <= IDX_W'(n_sweep_reg - CNT_W'(1));
            end
            if (cmd.pop_take) begin
                if (rd_reg.ok) begin
                    head_reg <= rd_reg.nxt;
                end else begin
                    head_ok_reg <= 1'b0;
                end
            end
            if (cmd.free_link) begin
                if (!head_ok_reg) begin
                    head_reg    <= fidx;
                    head_ok_reg <= 1'b1;
                end
                tail_reg <= fidx;
            end
        end
    end

    // Link memory: one write port, one registered read port.
    link_t            link_mem [DEPTH];
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    link_t            wr_data;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = sweep_reg;
        wr_data = '0;
        if (cmd.sweep_step) begin
            wr_en       = 1'b1;
            wr_data.ok  = (32'(sweep_reg) + 32'd1) < 32'(n_sweep_reg);
            wr_data.nxt = sweep_reg + IDX_W'(1);
        end else if (cmd.free_clear) begin
            wr_en   = 1'b1;
            wr_addr = fidx;
        end else if (cmd.free_link) begin
            wr_en       = head_ok_reg;
            wr_addr     = tail_reg;
            wr_data.ok  = 1'b1;
            wr_data.nxt = fidx;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            link_mem[wr_addr] <= wr_data;
        end
        if (cmd.pop_read) begin
            rd_reg <= link_mem[head_reg];
        end
    end

    // Address unit: the product is registered alongside the memory read.
    logic [IDX_W-1:0]  cap_idx_reg;
    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (cmd.pop_read) begin
            cap_idx_reg <= head_reg;
            prod_reg    <= PROD_W'(head_reg) * PROD_W'(size_reg);
        end
    end

    // Output register.
    logic      out_valid_reg;
    pbfl_out_t out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.status <= cmd.out_status;
            if (cmd.out_from_pop) begin
                out_reg.buffer_index   <= FIDX_W'(cap_idx_reg);
                out_reg.buffer_address <= base_reg + ADDR_W'(prod_reg);
                out_reg.last           <= (remain_reg == RB_W'(1));
            end else begin
                out_reg.buffer_index   <= '0;
                out_reg.buffer_address <= '0;
                out_reg.last           <= 1'b1;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        stat.in_cmd        = s_data.cmd;
        stat.in_count_zero = (s_data.alloc_count == '0);
        stat.head_ok       = head_ok_reg;
        stat.remain_one    = (remain_reg == RB_W'(1));
        stat.out_free      = !out_valid_reg || m_ready;
        stat.sweep_done    = sweep_done;
        stat.free_bad      = 32'(in_reg.free_index) >= 32'(n_cur);
    end

endmodule

### rtl/packet_buffer_free_list_top.sv
// Top level of the packet buffer free list: a linked FIFO of free buffer indices.
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      s_data   (pbfl_in_t: cmd, alloc_count, free_index)
// m_        out        m_valid / m_ready      m_data   (pbfl_out_t: status, index, address, last)
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An allocate gives each buffer through the link memory read of the head entry and the
// head update that depends on it, with the address multiply done next to the read. A free
// clears the freed entry, then links it behind the tail through the single write port
// (into an empty list it becomes the head), then hands its result to the output. A
// reinitialize rewrites the whole link memory, then gives its result. After reset the same
// sweep runs with s_ready low; configuration writes are taken throughout. A stalled m_ready
// holds the block only when a new result is due; the next item is accepted while one result waits.

module packet_buffer_free_list_top import pbfl_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int MAX_BATCH = MAX_BATCH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pbfl_in_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pbfl_out_t            m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    pbfl_cmd_t  cmd;
    pbfl_stat_t stat;

    // Configuration registers are plain flops and take a write in any cycle.
    assign cfg_ready = 1'b1;

    pbfl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    pbfl_datapath #(
        .DEPTH     (DEPTH),
        .MAX_BATCH (MAX_BATCH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

### test/packet_buffer_free_list_top_test.sv
// Self-checking testbench for the packet buffer free list top level.
`timescale 1ns / 1ps

module packet_buffer_free_list_top_test;
    import pbfl_pkg::*;

    // The block is built with its default pool depth and batch size.
    localparam int DEPTH     = DEPTH_DEFAULT;
    localparam int MAX_BATCH = MAX_BATCH_DEFAULT;

    // Codes that the package leaves unnamed but that the fields can carry.
    localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // An allocate of zero buffers gives no result. A drain lets the block settle after
    // the last owed result has come back.
    localparam int SETTLE_CYCLES = 32;
    localparam int TAIL_CYCLES   = 64;
    localparam int HOLD_CYCLES   = 600;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 20;

    // The tracker mirrors the free list: it predicts the results of every accepted
    // command and compares each returned result with the oldest one still owed.
    class buffer_pool_tracker;
        logic [ADDR_W-1:0]  base_address;
        logic [SIZE_W-1:0]  buffer_size;
        logic [ENTRY_W-1:0] entries_in_use;
        logic [FIDX_W-1:0]  head_index;
        bit                 head_ok;
        logic [FIDX_W-1:0]  tail_index;
        logic [FIDX_W-1:0]  next_link [DEPTH];
        bit                 link_ok [DEPTH];
        pbfl_out_t          owed_results [$];
        logic [FIDX_W-1:0]  given_out [$];
        int                 errors;

        function new();
            base_address   = BASE_RESET;
            buffer_size    = SIZE_RESET;
            entries_in_use = ENTRIES_RESET;
            errors         = 0;
            rebuild_list();
        endfunction

        function int entry_count();
            int n;
            n = int'(entries_in_use);
            if (n < 1) n = 1;
            if (n > DEPTH) n = DEPTH;
            return n;
        endfunction

        function void rebuild_list();
            int n;
            n = entry_count();
            for (int i = 0; i < DEPTH; i++) begin
                next_link[i] = '0;
                link_ok[i]   = 1'b0;
            end
            for (int i = 0; i + 1 < n; i++) begin
                next_link[i] = FIDX_W'(i + 1);
                link_ok[i]   = 1'b1;
            end
            head_index = '0;
            head_ok    = 1'b1;
            tail_index = FIDX_W'(n - 1);
            given_out.delete();
        endfunction

        function void owe(logic [STATUS_W-1:0] status, logic [FIDX_W-1:0] idx,
                          logic [ADDR_W-1:0] addr, logic last);
            pbfl_out_t r;
            r.status         = status;
            r.buffer_index   = idx;
            r.buffer_address = addr;
            r.last           = last;
            owed_results.push_back(r);
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
            case (idx)
                CFG_BASE_ADDRESS:   base_address   = value;
                CFG_BUFFER_SIZE:    buffer_size    = value[SIZE_W-1:0];
                CFG_ENTRIES_IN_USE: entries_in_use = value[ENTRY_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_command(pbfl_in_t item);
            int                want;
            bit                dry;
            logic [FIDX_W-1:0] idx;
            logic [63:0]       product;
            case (item.cmd)
                CMD_ALLOC: begin
                    want = (int'(item.alloc_count) > MAX_BATCH) ? MAX_BATCH
                                                                : int'(item.alloc_count);
                    dry  = 1'b0;
                    for (int i = 0; i < want && !dry; i++) begin
                        if (!head_ok) begin
                            // The pool ran dry: one empty status closes the batch.
                            owe(STATUS_EMPTY, '0, '0, 1'b1);
                            dry = 1'b1;
                        end else begin
                            idx = head_index;
                            if (link_ok[idx]) head_index = next_link[idx];
                            else head_ok = 1'b0;
                            product = 64'(idx) * 64'(buffer_size) + 64'(base_address);
                            owe(STATUS_OK, idx, product[ADDR_W-1:0], (i + 1 == want));
                            given_out.push_back(idx);
                        end
                    end
                end
                CMD_FREE: begin
                    if (int'(item.free_index) >= entry_count()) begin
                        owe(STATUS_BAD_INDEX, '0, '0, 1'b1);
                    end else begin
                        idx          = item.free_index;
                        link_ok[idx] = 1'b0;
                        next_link[idx] = '0;
                        if (head_ok) begin
                            next_link[tail_index] = idx;
                            link_ok[tail_index]   = 1'b1;
                        end else begin
                            head_index = idx;
                            head_ok    = 1'b1;
                        end
                        tail_index = idx;
                        owe(STATUS_OK, '0, '0, 1'b1);
                        foreach (given_out[k]) begin
                            if (given_out[k] == idx) begin
                                given_out.delete(k);
                                break;
                            end
                        end
                    end
                end
                CMD_REINIT: begin
                    rebuild_list();
                    owe(STATUS_OK, '0, '0, 1'b1);
                end
                default: ;
            endcase
        endfunction

        function void mismatch(string what, logic [63:0] expected, logic [63:0] actual);
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, what, expected, actual);
        endfunction

        function void take_result(pbfl_out_t got);
            pbfl_out_t want;
            if (owed_results.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, expected nothing, actual %h",
                         $time, got);
                return;
            end
            want = owed_results.pop_front();
            if (got.status != want.status)
                mismatch("status", 64'(want.status), 64'(got.status));
            if (got.buffer_index != want.buffer_index)
                mismatch("buffer_index", 64'(want.buffer_index), 64'(got.buffer_index));
            if (got.buffer_address != want.buffer_address)
                mismatch("buffer_address", 64'(want.buffer_address),
                         64'(got.buffer_address));
            if (got.last != want.last)
                mismatch("last", 64'(want.last), 64'(got.last));
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    pbfl_in_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    pbfl_out_t            m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]    cfg_data  = '0;

    buffer_pool_tracker pool = new();

    // Idle rates in percent for each side, and a request counter for a long
    // receiver hold-off that the receiver process counts out on its own.
    int          tx_idle_pct = 7;
    int          rx_idle_pct = 7;
    int          hold_req    = 0;
    int          hold_seen   = 0;
    int          hold_left   = 0;
    int unsigned cycle_count = 0;

    packet_buffer_free_list_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // The watchdog ends a run that hangs, for example on a result that never comes.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("packet_buffer_free_list_top_test failed");
            $finish;
        end
    end

    // The receiver drops ready at random, except during a requested hold-off,
    // when it keeps ready low for a long stretch so that the block backs up.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // All three channels are observed at the clock edge with the values from before
    // the edge. A result accepted at an edge always belongs to an older item, so it
    // is checked before the item accepted at the same edge is predicted.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) pool.take_result(m_data);
            if (s_valid && s_ready) pool.take_command(s_data);
            if (cfg_valid && cfg_ready) pool.write_register(cfg_index, cfg_data);
        end
    end

    function automatic pbfl_in_t make_item(logic [CMD_W-1:0] cmd, logic [COUNT_W-1:0] count,
                                           logic [FIDX_W-1:0] fidx);
        pbfl_in_t item;
        item.cmd         = cmd;
        item.alloc_count = count;
        item.free_index  = fidx;
        return item;
    endfunction

    // Offers one item and returns at the edge where it is accepted. Valid stays high
    // after acceptance so that back-to-back items need no second assignment; it only
    // drops when the sender idles or pauses.
    task automatic send_item(input pbfl_in_t item);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    // The sender stops and waits until every owed result has come back, then lets
    // the block settle for the given number of cycles.
    task automatic drain(input int settle);
        s_valid <= 1'b0;
        do @(posedge aclk); while (pool.owed_results.size() != 0);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_config(input logic [CFG_IDX_W-1:0] idx,
                                input logic [ADDR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_pool(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size,
                            input logic [ENTRY_W-1:0] entries);
        write_config(CFG_BASE_ADDRESS, base);
        write_config(CFG_BUFFER_SIZE, ADDR_W'(size));
        write_config(CFG_ENTRIES_IN_USE, ADDR_W'(entries));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        pbfl_in_t           item;
        logic [ADDR_W-1:0]  base;
        logic [SIZE_W-1:0]  size;
        logic [ENTRY_W-1:0] entries;
        int                 counted;
        int                 pick;

        // Reset is held once, at the start of the run.
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // With the reset settings the whole pool of 4096 buffers is free in order.
        // Batches of one, of the largest size and of an oversized count come first,
        // then a count of zero, the free index extremes, an unused command and a
        // buffer that is freed twice.
        send_item(make_item(CMD_ALLOC, 7'd1, 12'd0));
        send_item(make_item(CMD_ALLOC, 7'd64, 12'hFFF));
        send_item(make_item(CMD_ALLOC, 7'd127, 12'd0));
        send_item(make_item(CMD_ALLOC, 7'd0, 12'd0));
        send_item(make_item(CMD_FREE, 7'd0, 12'd0));
        send_item(make_item(CMD_FREE, 7'd127, 12'd4095));
        send_item(make_item(CMD_UNUSED, 7'd127, 12'hFFF));
        send_item(make_item(CMD_FREE, 7'd0, 12'd5));
        send_item(make_item(CMD_FREE, 7'd0, 12'd5));
        drain(SETTLE_CYCLES);

        // A pool of three buffers at the top of the address space with the widest
        // buffer size, so the addresses wrap. Out of range frees are rejected, the
        // pool runs dry in the middle of a batch and while already empty, a free
        // restarts the head, and a second free of the same buffer links it to itself.
        set_pool(48'hFFFF_FFFF_FFFF, 22'h3F_FFFF, 13'd3);
        send_item(make_item(CMD_FREE, 7'd0, 12'd3));
        send_item(make_item(CMD_FREE, 7'd0, 12'd4095));
        send_item(make_item(CMD_REINIT, 7'd0, 12'd0));
        send_item(make_item(CMD_ALLOC, 7'd2, 12'd0));
        send_item(make_item(CMD_ALLOC, 7'd5, 12'd0));
        send_item(make_item(CMD_ALLOC, 7'd1, 12'd0));
        send_item(make_item(CMD_FREE, 7'd0, 12'd1));
        send_item(make_item(CMD_FREE, 7'd0, 12'd1));
        send_item(make_item(CMD_ALLOC, 7'd3, 12'd0));
        drain(SETTLE_CYCLES);

        // A zero entry count is clamped to one buffer, and a zero buffer size puts
        // every buffer at the base address.
        set_pool(48'h1234_5678_9ABC, 22'd0, 13'd0);
        send_item(make_item(CMD_REINIT, 7'd0, 12'd0));
        send_item(make_item(CMD_ALLOC, 7'd1, 12'd0));
        send_item(make_item(CMD_FREE, 7'd0, 12'd0));
        send_item(make_item(CMD_FREE, 7'd0, 12'd1));
        send_item(make_item(CMD_ALLOC, 7'd3, 12'd0));
        drain(SETTLE_CYCLES);

        // An entry count above the depth is clamped, and a write to the unused
        // register index changes nothing. The list is not rebuilt here, so the new
        // count only widens the range check.
        write_config(CFG_UNUSED, 48'hFFFF_FFFF_FFFF);
        set_pool(48'd0, 22'd1, 13'h1FFF);
        send_item(make_item(CMD_FREE, 7'd0, 12'd4095));
        send_item(make_item(CMD_ALLOC, 7'd64, 12'hFFF));
        drain(SETTLE_CYCLES);

        // Random phases. Each picks new settings, often with a small pool so that
        // batches run it dry, and then mostly sends allocates of a few buffers and
        // frees of buffers that are out, with some noise mixed in.
        for (int phase = 0; phase < PHASES; phase++) begin
            case ($urandom_range(2))
                0:       base = '0;
                1:       base = 48'hFFFF_FFFF_FFFF;
                default: base = {16'($urandom), 32'($urandom)};
            endcase
            case ($urandom_range(5))
                0:       size = '0;
                1:       size = 22'd1;
                2:       size = 22'd2048;
                3:       size = 22'd2097152;
                4:       size = 22'h3F_FFFF;
                default: size = 22'($urandom);
            endcase
            case ($urandom_range(5))
                0:       entries = 13'd0;
                1:       entries = 13'd1;
                2:       entries = 13'($urandom_range(2, 64));
                3:       entries = 13'd4096;
                4:       entries = 13'h1FFF;
                default: entries = 13'($urandom);
            endcase
            set_pool(base, size, entries);

            // One phase runs with no idling on either side.
            tx_idle_pct = (phase == 3) ? 0 : 7;
            rx_idle_pct = (phase == 3) ? 0 : 7;

            // In another phase the receiver holds off while the sender keeps offering
            // items, so the block fills up and stalls its input.
            if (phase == 5) hold_req <= hold_req + 1;

            if (phase == 0 || $urandom_range(1) == 1)
                send_item(make_item(CMD_REINIT, 7'($urandom), 12'($urandom)));

            counted = 0;
            while (counted < PHASE_ITEMS) begin
                item.alloc_count = 7'($urandom_range(0, 127));
                item.free_index  = 12'($urandom_range(0, 4095));
                pick = $urandom_range(99);
                if (pick < 48) begin
                    item.cmd = CMD_ALLOC;
                    if ($urandom_range(99) < 85)
                        item.alloc_count = 7'($urandom_range(1, 8));
                end else if (pick < 88) begin
                    item.cmd = CMD_FREE;
                    if (pool.given_out.size() != 0 && $urandom_range(9) < 8)
                        item.free_index =
                            pool.given_out[$urandom_range(pool.given_out.size() - 1)];
                end else if (pick < 92) begin
                    item.cmd = CMD_REINIT;
                end else begin
                    item.cmd = CMD_UNUSED;
                end
                send_item(item);
                // Items that the block ignores do not count toward the phase.
                if (item.cmd != CMD_UNUSED && !(item.cmd == CMD_ALLOC && item.alloc_count == 0))
                    counted++;
            end
            drain(SETTLE_CYCLES);
        end

        drain(TAIL_CYCLES);
        if (pool.errors == 0) begin
            $display("packet_buffer_free_list_top_test passed");
        end else begin
            $display("packet_buffer_free_list_top_test failed");
        end
        $finish;
    end

endmodule

### packet_buffer_free_list_top.f
rtl/pbfl_pkg.sv
rtl/pbfl_ctrl.sv
rtl/pbfl_datapath.sv
rtl/packet_buffer_free_list_top.sv
test/packet_buffer_free_list_top_test.sv
